### rtl/core/sklp_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sklp_pkg
// Shared constants and controller/datapath interface types of the string key
// linear probe table.
// -----------------------------------------------------------------------------
package sklp_pkg;

	localparam int TABLE_SLOTS_DEF   = 64;
	localparam int MAX_KEY_BYTES_DEF = 16;
	localparam int HANDLE_BITS_DEF   = 16;

	localparam logic [31:0] HASH_SEED    = 32'd5381;
	localparam logic [2:0]  SIZE_LG_RST  = 3'd6;

	// Result status codes.
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	// Opcodes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clr_wr;     // clear one occupied mark during the reset pass
		logic       acc;        // accumulate an accepted key byte
		logic       start_op;   // last byte accepted: latch start slot and operands
		logic       meta_rd;    // read the slot entry at the probe slot
		logic       meta_wr;    // claim the probe slot for the pending key
		logic       step_slot;  // advance the probe slot
		logic       byte_rd;    // read key byte at the byte index
		logic       byte_wr;    // copy the read key byte into the slot
		logic       step_byte;  // advance the byte index
		logic       res_ld;     // load the output register
		logic [2:0] res_status;
		logic       res_found;
	} sklp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic clr_done;
		logic last_ovf;
		logic op_search;
		logic occ;
		logic len_eq;
		logic len_zero;
		logic byte_eq;
		logic byte_last;
		logic sweep_end;
		logic out_busy;
	} sklp_sts_t;

endpackage

### rtl/core/sklp_dp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sklp_dp
// Datapath: hash accumulation, key buffer, slot tables and output register.
// -----------------------------------------------------------------------------
module sklp_dp #(
	parameter int TABLE_SLOTS   = sklp_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_KEY_BYTES = sklp_pkg::MAX_KEY_BYTES_DEF,
	parameter int HANDLE_BITS   = sklp_pkg::HANDLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data,
	input  logic              s_tuser,
	input  logic [23:0]       s_tdata,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [15:0]       m_tdata,
	output logic [2:0]        m_tuser,
	input  sklp_pkg::sklp_cmd_t cmd,
	output sklp_pkg::sklp_sts_t sts
);

	localparam int AW     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int SLOT_LG = $clog2(TABLE_SLOTS + 1) - 1;
	localparam int KW     = $clog2(MAX_KEY_BYTES + 1);
	localparam int IW     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int SKN    = TABLE_SLOTS * MAX_KEY_BYTES;
	localparam int SKW    = (SKN > 1) ? $clog2(SKN) : 1;
	localparam int HX     = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;

	logic [2:0]             size_lg_q;
	logic [AW-1:0]          hash_q;
	logic [KW-1:0]          len_q;
	logic                   ovf_q;
	logic                   op_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [AW-1:0]          slot_q;
	logic [AW-1:0]          n_q;
	logic [IW-1:0]          idx_q;
	logic [AW-1:0]          clr_addr_q;
	logic                   clr_done_q;

	logic [7:0]             kbuf_mem [MAX_KEY_BYTES];
	logic                   occ_mem [TABLE_SLOTS];
	logic [KW-1:0]          len_mem [TABLE_SLOTS];
	logic [HANDLE_BITS-1:0] hdl_mem [TABLE_SLOTS];
	logic [7:0]             skey_mem [SKN];

	logic                   occ_q;
	logic [KW-1:0]          mlen_q;
	logic [HANDLE_BITS-1:0] mhdl_q;
	logic [7:0]             kb_q;
	logic [7:0]             sk_q;

	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;
	logic [2:0]             m_tuser_q;

	logic [AW-1:0]          hash_next;
	logic [2:0]             lg1;
	logic [2:0]             lg_eff;
	logic [AW-1:0]          mask;
	logic [SKW-1:0]         sk_addr;
	logic                   len_full;
	logic [HX-1:0]          hdl_ext;
	logic [HX-1:0]          found_ext;

	assign hash_next = AW'({hash_q, 5'b0}) + hash_q + AW'(s_tdata[7:0]);
	assign lg1       = (size_lg_q == 3'd0) ? 3'd1 : size_lg_q;
	assign lg_eff    = (int'(lg1) > SLOT_LG) ? 3'(SLOT_LG) : lg1;
	assign mask      = AW'(((AW + 1)'(1) << lg_eff) - (AW + 1)'(1));
	assign sk_addr   = SKW'(slot_q) * SKW'(MAX_KEY_BYTES) + SKW'(idx_q);
	assign len_full  = (len_q == KW'(MAX_KEY_BYTES));
	assign hdl_ext   = HX'(s_tdata[23:8]);
	assign found_ext = HX'(mhdl_q);

	assign sts.clr_last  = (clr_addr_q == AW'(TABLE_SLOTS - 1));
	assign sts.clr_done  = clr_done_q;
	assign sts.last_ovf  = ovf_q | len_full;
	assign sts.op_search = (op_q == sklp_pkg::OP_SEARCH);
	assign sts.occ       = occ_q;
	assign sts.len_eq    = (mlen_q == len_q);
	assign sts.len_zero  = (len_q == '0);
	assign sts.byte_eq   = (kb_q == sk_q);
	assign sts.byte_last = ((KW'(idx_q) + KW'(1)) == len_q);
	assign sts.sweep_end = (n_q == mask);
	assign sts.out_busy  = m_tvalid_q & ~m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_lg_q  <= sklp_pkg::SIZE_LG_RST;
			hash_q     <= sklp_pkg::HASH_SEED[AW-1:0];
			len_q      <= '0;
			ovf_q      <= 1'b0;
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_lg_q <= cfg_wr_data;
			end
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (sts.clr_last) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.acc) begin
				hash_q <= hash_next;
				if (len_full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + KW'(1);
				end
			end
			if (cmd.res_ld) begin
				hash_q <= sklp_pkg::HASH_SEED[AW-1:0];
				len_q  <= '0;
				ovf_q  <= 1'b0;
			end
			if (cmd.res_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Operand and probe registers; payload only.
	always_ff @(posedge clk) begin
		if (cmd.start_op) begin
			slot_q <= hash_next & mask;
			n_q    <= '0;
			op_q   <= s_tuser;
			hdl_q  <= hdl_ext[HANDLE_BITS-1:0];
		end
		if (cmd.step_slot) begin
			slot_q <= (slot_q + AW'(1)) & mask;
			n_q    <= n_q + AW'(1);
		end
		if (cmd.meta_rd) begin
			idx_q <= '0;
		end else if (cmd.step_byte) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.res_ld) begin
			m_tuser_q <= cmd.res_status;
			m_tdata_q <= cmd.res_found ? found_ext[15:0] : 16'd0;
		end
	end

	// Key buffer memory.
	always_ff @(posedge clk) begin
		if (cmd.acc && !len_full) begin
			kbuf_mem[len_q[IW-1:0]] <= s_tdata[7:0];
		end
		if (cmd.byte_rd) begin
			kb_q <= kbuf_mem[idx_q];
		end
	end

	// Slot entry memories, all at the probe slot (or the clear address).
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			occ_mem[clr_addr_q] <= 1'b0;
		end else if (cmd.meta_wr) begin
			occ_mem[slot_q] <= 1'b1;
		end
		if (cmd.meta_wr) begin
			len_mem[slot_q] <= len_q;
			hdl_mem[slot_q] <= hdl_q;
		end
		if (cmd.meta_rd) begin
			occ_q  <= occ_mem[slot_q];
			mlen_q <= len_mem[slot_q];
			mhdl_q <= hdl_mem[slot_q];
		end
	end

	// Stored key bytes.
	always_ff @(posedge clk) begin
		if (cmd.byte_wr) begin
			skey_mem[sk_addr] <= kb_q;
		end
		if (cmd.byte_rd) begin
			sk_q <= skey_mem[sk_addr];
		end
	end

endmodule

### rtl/core/sklp_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sklp_ctrl
// Controller: clear pass, byte intake, probe walk and key compare sequencing.
// -----------------------------------------------------------------------------
module sklp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	output logic                s_tready,
	input  sklp_pkg::sklp_sts_t sts,
	output sklp_pkg::sklp_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_META_RD  = 9'b000000100,
		S_META_CHK = 9'b000001000,
		S_CMP_RD   = 9'b000010000,
		S_CMP_CHK  = 9'b000100000,
		S_CP_RD    = 9'b001000000,
		S_CP_WR    = 9'b010000000,
		S_RESULT   = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       acc;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid & s_tready;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.res_status = st_q;
		cmd.res_found  = (st_q == sklp_pkg::ST_FOUND);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.acc = acc;
				if (acc && s_tlast) begin
					cmd.start_op = 1'b1;
					if (sts.last_ovf) begin
						st_d    = sklp_pkg::ST_TOO_LONG;
						state_d = S_RESULT;
					end else begin
						state_d = S_META_RD;
					end
				end
			end
			S_META_RD: begin
				cmd.meta_rd = 1'b1;
				state_d     = S_META_CHK;
			end
			S_META_CHK: begin
				if (!sts.op_search) begin
					if (!sts.occ) begin
						cmd.meta_wr = 1'b1;
						if (sts.len_zero) begin
							st_d    = sklp_pkg::ST_INSERTED;
							state_d = S_RESULT;
						end else begin
							state_d = S_CP_RD;
						end
					end else if (sts.sweep_end) begin
						st_d    = sklp_pkg::ST_FULL;
						state_d = S_RESULT;
					end else begin
						cmd.step_slot = 1'b1;
						state_d       = S_META_RD;
					end
				end else begin
					if (!sts.occ) begin
						st_d    = sklp_pkg::ST_NOT_FOUND;
						state_d = S_RESULT;
					end else if (sts.len_eq && sts.len_zero) begin
						st_d    = sklp_pkg::ST_FOUND;
						state_d = S_RESULT;
					end else if (sts.len_eq) begin
						state_d = S_CMP_RD;
					end else if (sts.sweep_end) begin
						st_d    = sklp_pkg::ST_NOT_FOUND;
						state_d = S_RESULT;
					end else begin
						cmd.step_slot = 1'b1;
						state_d       = S_META_RD;
					end
				end
			end
			S_CMP_RD: begin
				cmd.byte_rd = 1'b1;
				state_d     = S_CMP_CHK;
			end
			S_CMP_CHK: begin
				if (sts.byte_eq && sts.byte_last) begin
					st_d    = sklp_pkg::ST_FOUND;
					state_d = S_RESULT;
				end else if (sts.byte_eq) begin
					cmd.step_byte = 1'b1;
					state_d       = S_CMP_RD;
				end else if (sts.sweep_end) begin
					st_d    = sklp_pkg::ST_NOT_FOUND;
					state_d = S_RESULT;
				end else begin
					cmd.step_slot = 1'b1;
					state_d       = S_META_RD;
				end
			end
			S_CP_RD: begin
				cmd.byte_rd = 1'b1;
				state_d     = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.byte_wr = 1'b1;
				if (sts.byte_last) begin
					st_d    = sklp_pkg::ST_INSERTED;
					state_d = S_RESULT;
				end else begin
					cmd.step_byte = 1'b1;
					state_d       = S_CP_RD;
				end
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			st_q    <= sklp_pkg::ST_INSERTED;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

### rtl/core/string_key_linear_probe_table.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// string_key_linear_probe_table
// Open-addressed symbol table keyed by byte strings, djb2 start slot and
// linear probing, with insert and search on the last byte of a key.
// -----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: key_byte[7:0], handle[23:8];
//                                     tuser: opcode; tlast: key_last
// m_*       out  m_tvalid/m_tready    tdata: found_handle[15:0]; tuser: status
// cfg_*     in   cfg_wr_en            cfg_wr_data: table_size_log2
//
// A non-last key byte is taken while the controller is idle. On the last byte
// the controller walks slots with an entry read and check per probed slot and
// a read and compare or write per key byte, then loads the result. After reset
// a clearing pass over all TABLE_SLOTS slots empties the occupied marks; no
// item is accepted during it. The result waits in an output register, so
// a stalled m_tready only holds the block once a second result is ready.
//
module string_key_linear_probe_table #(
	parameter int TABLE_SLOTS   = sklp_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_KEY_BYTES = sklp_pkg::MAX_KEY_BYTES_DEF,
	parameter int HANDLE_BITS   = sklp_pkg::HANDLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,  // table_size_log2
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,      // key_byte[7:0], handle[23:8]
	input  logic        s_tuser,      // opcode
	input  logic        s_tlast,      // key_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,      // found_handle[15:0]
	output logic [2:0]  m_tuser       // status[2:0]
);

	sklp_pkg::sklp_cmd_t cmd;
	sklp_pkg::sklp_sts_t sts;

	// The controller sequences every step; the datapath holds all storage.
	sklp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sklp_dp #(
		.TABLE_SLOTS   (TABLE_SLOTS),
		.MAX_KEY_BYTES (MAX_KEY_BYTES),
		.HANDLE_BITS   (HANDLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cmd         (cmd),
		.sts         (sts)
	);

`ifndef SYNTHESIS
	// A slot is only claimed when the entry just read shows it empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.meta_wr |-> !sts.occ)
		else $error("insert claimed an occupied slot");

	// A new result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> !(m_tvalid && !m_tready))
		else $error("result loaded over a pending result");

	// No key byte is taken before the clearing pass has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> sts.clr_done)
		else $error("input accepted during the clearing pass");
`endif

endmodule
